/* hw/rtl/rgb_depth_frame_pairing_sync_assert.svh */
// Assertion macros for the frame pairing block checkers.
// Needs nothing else; take in by `include.
`ifndef RGB_DEPTH_FRAME_PAIRING_SYNC_ASSERT_SVH
`define RGB_DEPTH_FRAME_PAIRING_SYNC_ASSERT_SVH
// same-cycle implication
`define RDFP_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rdfp assertion failed");
// next-cycle implication
`define RDFP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rdfp assertion failed");
`endif

/* hw/rtl/rdfp_pkg.sv */
// Shared constants, types and register indexes of the frame pairing block.
// No dependencies.
package rdfp_pkg;
	localparam int SYNC_QUEUE_LENGTH = 20;
	localparam int STORE_CAP = (SYNC_QUEUE_LENGTH * 3) / 4 + 1;
	localparam int IDX_W = $clog2(STORE_CAP);
	localparam int CNT_W = $clog2(STORE_CAP + 1);
	localparam int DRAIN_START = (SYNC_QUEUE_LENGTH * 3) / 4;
	localparam int DRAIN_STOP = SYNC_QUEUE_LENGTH / 4;
	localparam int TS_W = 48;
	localparam int TAG_W = 16;
	localparam int SEQ_W = 32;
	localparam int SKIP_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_LIM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_UNM = 3'd5;

	localparam logic KIND_SAVE = 1'b0;
	localparam logic KIND_FOLDER = 1'b1;

	typedef struct packed {
		logic event_kind;
		logic is_depth;
		logic [TS_W-1:0] ts;
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] seq;
		logic paired;
	} res_t;

	typedef struct packed {
		logic start;
		logic [SEQ_W-1:0] dividend;
		logic [SKIP_W:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic [SKIP_W:0] rem;
	} mod_rsp_t;
endpackage

/* hw/rtl/rdfp_frame_if.sv */
// Frame arrival channel.
// Uses rdfp_pkg widths.
interface rdfp_frame_if;
	logic valid;
	logic ready;
	logic is_depth;
	logic [rdfp_pkg::TS_W-1:0] timestamp_us;
	logic [rdfp_pkg::TAG_W-1:0] frame_tag;
	logic [15:0] depth_mean;
	modport source(output valid, is_depth, timestamp_us, frame_tag, depth_mean, input ready);
	modport sink(input valid, is_depth, timestamp_us, frame_tag, depth_mean, output ready);
endinterface

/* hw/rtl/rdfp_result_if.sv */
// Result channel: save and folder events.
// Uses rdfp_pkg widths.
interface rdfp_result_if;
	logic valid;
	logic ready;
	logic event_kind;
	logic out_is_depth;
	logic [rdfp_pkg::TS_W-1:0] out_timestamp_us;
	logic [rdfp_pkg::TAG_W-1:0] out_frame_tag;
	logic [rdfp_pkg::SEQ_W-1:0] sequence_number;
	logic paired;
	logic last;
	modport source(output valid, event_kind, out_is_depth, out_timestamp_us, out_frame_tag,
		sequence_number, paired, last, input ready);
	modport sink(input valid, event_kind, out_is_depth, out_timestamp_us, out_frame_tag,
		sequence_number, paired, last, output ready);
endinterface

/* hw/rtl/rdfp_cfg_if.sv */
// Configuration write channel.
// Uses rdfp_pkg widths.
interface rdfp_cfg_if;
	logic valid;
	logic ready;
	logic [rdfp_pkg::CFG_IDX_W-1:0] index;
	logic [rdfp_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/rdfp_mod_unit.sv */
// Bit-serial remainder unit: sequence number modulo (frame_skip + 1).
// Uses rdfp_pkg; one quotient bit per cycle.
module rdfp_mod_unit (
	input  logic clk,
	input  logic arst_n,
	input  rdfp_pkg::mod_req_t req,
	output rdfp_pkg::mod_rsp_t rsp
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [rdfp_pkg::SEQ_W-1:0] dvd_q;
	logic [rdfp_pkg::SKIP_W:0] rem_q, div_q;
	logic [rdfp_pkg::SKIP_W+1:0] trial;
	logic [rdfp_pkg::SKIP_W+1:0] div_ext;

	assign trial = {rem_q, dvd_q[rdfp_pkg::SEQ_W-1]};
	assign div_ext = {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rdfp_pkg::SEQ_W-2:0], 1'b0};
			if (trial >= div_ext)
				rem_q <= (rdfp_pkg::SKIP_W+1)'(trial - div_ext);
			else
				rem_q <= trial[rdfp_pkg::SKIP_W:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem = rem_q;
endmodule

/* hw/rtl/rgb_depth_frame_pairing_sync.sv */
// Colour/depth frame pairing and save scheduler, top level.
// Uses rdfp_pkg, the three channel interfaces and rdfp_mod_unit.
// Stored frame runs SEARCH, INSERT, DCHK, FIN; folder word PUSH, DCHK, FIN; dropped/dark IDLE.
// Drain step: DCHK, MODW (remainder unit), GAP, DECIDE, PUSH; up to 11 steps, plus stalls.
// Throughput: one frame at a time; ready only when the sequencer is idle.
// Reset: asynchronous, clears control state; lens starts covered, store empty.
module rgb_depth_frame_pairing_sync (
	input logic clk,
	input logic arst_n,
	rdfp_frame_if.sink frame,
	rdfp_result_if.source result,
	rdfp_cfg_if.sink cfg
);
	localparam int IW = rdfp_pkg::IDX_W;
	localparam int CW = rdfp_pkg::CNT_W;
	localparam int CAP = rdfp_pkg::STORE_CAP;
	localparam int TW = rdfp_pkg::TS_W;
	localparam int GW = rdfp_pkg::TAG_W;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SEARCH = 9'b000000010,
		ST_INSERT = 9'b000000100,
		ST_DCHK   = 9'b000001000,
		ST_MODW   = 9'b000010000,
		ST_GAP    = 9'b000100000,
		ST_DECIDE = 9'b001000000,
		ST_PUSH   = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [TW-1:0] times_q [CAP];
	logic [GW:0] info_q [CAP];
	logic [CW-1:0] count_q, pos_q;
	logic [7:0] run_q;
	logic covered_q;
	logic [rdfp_pkg::SEQ_W-1:0] seq_q;
	logic capture_q, save_unm_q;
	logic [15:0] thr_q;
	logic [7:0] lim_q, skip_q;
	logic [31:0] timeout_q;
	logic drain_q;
	logic [1:0] n_q;
	logic pend_v_q, out_v_q, out_last_q;
	rdfp_pkg::res_t r0_q, r1_q, pend_q, out_q;
	logic [TW-1:0] ts_q, d_q;
	logic [GW:0] fin_q;

	logic acc, cfg_we, slot_free, out_load, pend_take;
	logic [7:0] run_nx;
	logic [TW-1:0] ga, gb, gap_v, srch_t;
	logic ins_we, drain_go, do_pair, keep, drop2;
	logic [CW-1:0] cnt_ins;
	rdfp_pkg::res_t folder_r, save0_r, save1_r;
	rdfp_pkg::mod_req_t mreq;
	rdfp_pkg::mod_rsp_t mrsp;

	assign acc = frame.valid && frame.ready;
	assign frame.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cfg_we = cfg.valid;
	assign slot_free = !out_v_q || result.ready;
	assign run_nx = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
	assign srch_t = times_q[pos_q[IW-1:0]];
	assign ins_we = (state_q == ST_INSERT) && (count_q < CW'(CAP));
	assign cnt_ins = ins_we ? count_q + CW'(1) : count_q;
	assign drain_go = drain_q && (count_q > CW'(rdfp_pkg::DRAIN_STOP)) && (count_q >= CW'(3));

	// shared gap unit
	assign ga = (state_q == ST_GAP) ? times_q[0] : times_q[2];
	assign gb = times_q[1];
	assign gap_v = (ga > gb) ? ga - gb : gb - ga;

	assign keep = (mrsp.rem == '0);
	assign do_pair = (info_q[0][GW] != info_q[1][GW]) && (d_q <= {16'd0, timeout_q})
		&& !(gap_v < d_q);
	assign drop2 = do_pair;

	assign pend_take = (state_q == ST_PUSH) && (n_q != 2'd0) && (!pend_v_q || slot_free);
	assign out_load = ((state_q == ST_PUSH) && (n_q != 2'd0) && pend_v_q && slot_free)
		|| ((state_q == ST_FIN) && pend_v_q && slot_free);

	assign folder_r = '{event_kind: rdfp_pkg::KIND_FOLDER, is_depth: 1'b0, ts: '0,
		tag: '0, seq: '0, paired: 1'b0};
	assign save0_r = '{event_kind: rdfp_pkg::KIND_SAVE, is_depth: info_q[0][GW], ts: times_q[0],
		tag: info_q[0][GW-1:0], seq: seq_q, paired: do_pair};
	assign save1_r = '{event_kind: rdfp_pkg::KIND_SAVE, is_depth: info_q[1][GW], ts: times_q[1],
		tag: info_q[1][GW-1:0], seq: seq_q, paired: 1'b1};

	assign mreq.start = (state_q == ST_DCHK) && drain_go;
	assign mreq.dividend = seq_q;
	assign mreq.divisor = {1'b0, skip_q} + 9'd1;

	rdfp_mod_unit u_mod (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			run_q <= '0;
			covered_q <= 1'b1;
			seq_q <= '0;
			capture_q <= 1'b0;
			thr_q <= 16'd100;
			lim_q <= 8'd20;
			timeout_q <= 32'd2000000;
			skip_q <= '0;
			save_unm_q <= 1'b1;
			drain_q <= 1'b0;
			n_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg.index)
					rdfp_pkg::REG_CAPTURE: begin
						capture_q <= cfg.data[0];
						count_q <= '0;
					end
					rdfp_pkg::REG_DARK_THR: thr_q <= cfg.data[15:0];
					rdfp_pkg::REG_DARK_LIM: lim_q <= cfg.data[7:0];
					rdfp_pkg::REG_TIMEOUT: timeout_q <= cfg.data;
					rdfp_pkg::REG_SKIP: skip_q <= cfg.data[7:0];
					rdfp_pkg::REG_SAVE_UNM: save_unm_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (out_load)
				out_v_q <= 1'b1;
			else if (result.ready)
				out_v_q <= 1'b0;
			if (pend_take) begin
				pend_v_q <= 1'b1;
				n_q <= n_q - 2'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && capture_q) begin
						pos_q <= '0;
						if (frame.is_depth) begin
							if (frame.depth_mean < thr_q) begin
								run_q <= run_nx;
								if (run_nx > lim_q) begin
									covered_q <= 1'b1;
									if (seq_q != '0) begin
										seq_q <= '0;
										n_q <= 2'd1;
										drain_q <= 1'b0;
										state_q <= ST_PUSH;
									end
								end
							end else begin
								run_q <= '0;
								covered_q <= 1'b0;
								state_q <= ST_SEARCH;
							end
						end else if (!covered_q) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (pos_q < count_q && srch_t <= ts_q)
						pos_q <= pos_q + CW'(1);
					else
						state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					count_q <= cnt_ins;
					drain_q <= (cnt_ins > CW'(rdfp_pkg::DRAIN_START));
					state_q <= ST_DCHK;
				end
				ST_DCHK: state_q <= drain_go ? ST_MODW : ST_FIN;
				ST_MODW: if (mrsp.done) state_q <= ST_GAP;
				ST_GAP: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					count_q <= count_q - (drop2 ? CW'(2) : CW'(1));
					seq_q <= seq_q + 32'd1;
					if (keep && do_pair)
						n_q <= 2'd2;
					else if (keep && save_unm_q)
						n_q <= 2'd1;
					else
						n_q <= 2'd0;
					state_q <= ST_PUSH;
				end
				ST_PUSH: if (n_q == 2'd0) state_q <= ST_DCHK;
				ST_FIN: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ts_q <= frame.timestamp_us;
			fin_q <= {frame.is_depth, frame.frame_tag};
			r0_q <= folder_r;
		end
		if (state_q == ST_GAP)
			d_q <= gap_v;
		if (ins_we) begin
			for (int j = 1; j < CAP; j++) begin
				if (CW'(j) > pos_q) begin
					times_q[j] <= times_q[j-1];
					info_q[j] <= info_q[j-1];
				end
			end
			for (int j = 0; j < CAP; j++) begin
				if (CW'(j) == pos_q) begin
					times_q[j] <= ts_q;
					info_q[j] <= fin_q;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			r0_q <= save0_r;
			r1_q <= save1_r;
			for (int j = 0; j < CAP; j++) begin
				times_q[j] <= drop2 ? times_q[(j + 2 < CAP) ? j + 2 : CAP - 1]
					: times_q[(j + 1 < CAP) ? j + 1 : CAP - 1];
				info_q[j] <= drop2 ? info_q[(j + 2 < CAP) ? j + 2 : CAP - 1]
					: info_q[(j + 1 < CAP) ? j + 1 : CAP - 1];
			end
		end
		if (pend_take) begin
			pend_q <= r0_q;
			r0_q <= r1_q;
		end
		if (out_load) begin
			out_q <= pend_q;
			out_last_q <= (state_q == ST_FIN);
		end
	end

	assign result.valid = out_v_q;
	assign result.event_kind = out_q.event_kind;
	assign result.out_is_depth = out_q.is_depth;
	assign result.out_timestamp_us = out_q.ts;
	assign result.out_frame_tag = out_q.tag;
	assign result.sequence_number = out_q.seq;
	assign result.paired = out_q.paired;
	assign result.last = out_last_q;
endmodule

/* hw/rtl/rdfp_checker.sv */
// Port-level checker for the frame pairing block, with its bind.
// Uses rgb_depth_frame_pairing_sync_assert.svh.
`include "rgb_depth_frame_pairing_sync_assert.svh"
module rdfp_checker (
	input logic clk,
	input logic arst_n,
	input logic frame_ready,
	input logic result_valid,
	input logic result_ready,
	input logic event_kind,
	input logic [47:0] out_timestamp_us,
	input logic [31:0] sequence_number,
	input logic paired,
	input logic last
);
	`RDFP_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid)
	`RDFP_ASSERT_IMP(a_busy_mid, clk, arst_n, result_valid && !last, !frame_ready)
	`RDFP_ASSERT_IMP(a_folder_zero, clk, arst_n, result_valid && event_kind,
		out_timestamp_us == 48'd0 && sequence_number == 32'd0 && !paired)
	`RDFP_ASSERT_IMP(a_folder_last, clk, arst_n, result_valid && event_kind, last)
endmodule

bind rgb_depth_frame_pairing_sync rdfp_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.frame_ready(frame.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.event_kind(result.event_kind),
	.out_timestamp_us(result.out_timestamp_us),
	.sequence_number(result.sequence_number),
	.paired(result.paired),
	.last(result.last)
);
